@@ sv/bphs_pkg.sv @@
`default_nettype none
package bphs_pkg;

  localparam int unsigned TableDepth = 1024;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned CntW       = IdxW + 1;
  localparam int unsigned EntryW     = 32;

  localparam logic [63:0] Mix1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] Mix2 = 64'h94d049bb133111eb;

  localparam logic [1:0] ModeFind   = 2'd0;
  localparam logic [1:0] ModeInsert = 2'd1;
  localparam logic [1:0] ModeRemove = 2'd2;

  localparam logic [2:0] StFound    = 3'd0;
  localparam logic [2:0] StAbsent   = 3'd1;
  localparam logic [2:0] StInserted = 3'd2;
  localparam logic [2:0] StPresent  = 3'd3;
  localparam logic [2:0] StRemoved  = 3'd4;
  localparam logic [2:0] StMissing  = 3'd5;
  localparam logic [2:0] StFull     = 3'd6;
  localparam logic [2:0] StEqual    = 3'd7;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_HASH, S_RD, S_CHK, S_SCAN_RD, S_SCAN_CHK, S_DONE
  } state_e;

  typedef logic [IdxW-1:0]   idx_t;
  typedef logic [EntryW-1:0] entry_t;

endpackage
`default_nettype wire

@@ sv/body_pair_hash_set.sv @@
// Set of unordered body slot pairs in a 1024-bucket linear-probing table.
// After reset a clearing pass zeroes the table, during which no item is
// taken. Each item is then hashed on one shared 32x32 multiplier, probed
// bucket by bucket through the table RAM read port and output; a remove
// also re-hashes and re-probes every later entry of the cluster. Equal
// slots skip hashing and probing.
`default_nettype none
module body_pair_hash_set (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [39:0] s_axis_tdata_i,   // mode[1:0], slot_a[17:2], slot_b[33:18], zero
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // status[2:0], bucket[12:3], zero
);

  localparam int unsigned CntW = bphs_pkg::CntW;

  bphs_pkg::state_e state_q, state_d;
  bphs_pkg::idx_t   clr_q, clr_d, idx_q, idx_d, scan_q, scan_d, bucket_q, bucket_d;
  bphs_pkg::idx_t   obucket_q, obucket_d, hbucket, waddr, raddr;
  bphs_pkg::entry_t entry_q, entry_d, moved_q, moved_d, wdata, rdata, key;
  logic [CntW-1:0]  n_q, n_d, sn_q, sn_d;
  logic [1:0]       mode_q, mode_d;
  logic [2:0]       status_q, status_d, ostatus_q, ostatus_d;
  logic [15:0]      sa, sb, lo, hi;
  logic             reins_q, reins_d, hstart_q, hstart_d, hdone, we;
  logic             ovalid_q, ovalid_d;

  bphs_ram #(.WIDTH(bphs_pkg::EntryW), .DEPTH(bphs_pkg::TableDepth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign key = reins_q ? moved_q : entry_q;

  bphs_hash u_hash (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (hstart_q),
    .entry_i  (key),
    .done_o   (hdone),
    .bucket_o (hbucket)
  );

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    idx_d     = idx_q;
    n_d       = n_q;
    scan_d    = scan_q;
    sn_d      = sn_q;
    mode_d    = mode_q;
    entry_d   = entry_q;
    moved_d   = moved_q;
    reins_d   = reins_q;
    status_d  = status_q;
    bucket_d  = bucket_q;
    hstart_d  = 1'b0;
    ovalid_d  = ovalid_q & ~m_axis_tready_i;
    ostatus_d = ostatus_q;
    obucket_d = obucket_q;
    we        = 1'b0;
    waddr     = idx_q;
    wdata     = '0;
    raddr     = idx_q;
    s_axis_tready_o = 1'b0;
    sa = s_axis_tdata_i[17:2];
    sb = s_axis_tdata_i[33:18];
    lo = (sa < sb) ? sa : sb;
    hi = (sa < sb) ? sb : sa;

    unique case (state_q)
      bphs_pkg::S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        clr_d = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = bphs_pkg::S_IDLE;
        end
      end
      bphs_pkg::S_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          mode_d  = s_axis_tdata_i[1:0];
          entry_d = {lo, hi};
          reins_d = 1'b0;
          if (sa == sb) begin
            status_d = bphs_pkg::StEqual;
            bucket_d = '0;
            state_d  = bphs_pkg::S_DONE;
          end else begin
            hstart_d = 1'b1;
            state_d  = bphs_pkg::S_HASH;
          end
        end
      end
      bphs_pkg::S_HASH: begin
        if (hdone) begin
          idx_d   = hbucket;
          n_d     = '0;
          state_d = bphs_pkg::S_RD;
        end
      end
      bphs_pkg::S_RD: begin
        state_d = bphs_pkg::S_CHK;
      end
      bphs_pkg::S_CHK: begin
        if (rdata == '0 || rdata == key) begin
          if (reins_q) begin
            if (rdata == '0) begin
              we    = 1'b1;
              wdata = moved_q;
            end
            scan_d  = scan_q + 1'b1;
            sn_d    = sn_q + 1'b1;
            state_d = (sn_q + 1'b1 == CntW'(bphs_pkg::TableDepth)) ?
                      bphs_pkg::S_DONE : bphs_pkg::S_SCAN_RD;
          end else begin
            bucket_d = idx_q;
            state_d  = bphs_pkg::S_DONE;
            priority if (mode_q == bphs_pkg::ModeInsert) begin
              if (rdata == '0) begin
                we       = 1'b1;
                wdata    = entry_q;
                status_d = bphs_pkg::StInserted;
              end else begin
                status_d = bphs_pkg::StPresent;
              end
            end else if (mode_q == bphs_pkg::ModeRemove) begin
              if (rdata == '0) begin
                status_d = bphs_pkg::StMissing;
              end else begin
                we       = 1'b1;
                status_d = bphs_pkg::StRemoved;
                scan_d   = idx_q + 1'b1;
                sn_d     = '0;
                state_d  = bphs_pkg::S_SCAN_RD;
              end
            end else begin
              status_d = (rdata == '0) ? bphs_pkg::StAbsent : bphs_pkg::StFound;
            end
          end
        end else begin
          idx_d = idx_q + 1'b1;
          n_d   = n_q + 1'b1;
          if (n_q + 1'b1 == CntW'(bphs_pkg::TableDepth)) begin
            if (reins_q) begin
              scan_d  = scan_q + 1'b1;
              sn_d    = sn_q + 1'b1;
              state_d = (sn_q + 1'b1 == CntW'(bphs_pkg::TableDepth)) ?
                        bphs_pkg::S_DONE : bphs_pkg::S_SCAN_RD;
            end else begin
              status_d = bphs_pkg::StFull;
              bucket_d = '0;
              state_d  = bphs_pkg::S_DONE;
            end
          end else begin
            state_d = bphs_pkg::S_RD;
          end
        end
      end
      bphs_pkg::S_SCAN_RD: begin
        raddr   = scan_q;
        state_d = bphs_pkg::S_SCAN_CHK;
      end
      bphs_pkg::S_SCAN_CHK: begin
        if (rdata == '0) begin
          state_d = bphs_pkg::S_DONE;
        end else begin
          we       = 1'b1;
          waddr    = scan_q;
          moved_d  = rdata;
          reins_d  = 1'b1;
          hstart_d = 1'b1;
          state_d  = bphs_pkg::S_HASH;
        end
      end
      bphs_pkg::S_DONE: begin
        if (!ovalid_q || m_axis_tready_i) begin
          ovalid_d  = 1'b1;
          ostatus_d = status_q;
          obucket_d = bucket_q;
          state_d   = bphs_pkg::S_IDLE;
        end
      end
      default: state_d = bphs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= bphs_pkg::S_CLEAR;
      clr_q    <= '0;
      hstart_q <= 1'b0;
      ovalid_q <= 1'b0;
      reins_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      hstart_q <= hstart_d;
      ovalid_q <= ovalid_d;
      reins_q  <= reins_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    n_q       <= n_d;
    scan_q    <= scan_d;
    sn_q      <= sn_d;
    mode_q    <= mode_d;
    entry_q   <= entry_d;
    moved_q   <= moved_d;
    status_q  <= status_d;
    bucket_q  <= bucket_d;
    ostatus_q <= ostatus_d;
    obucket_q <= obucket_d;
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = {3'b0, obucket_q, ostatus_q};

  a_equal_bucket_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && ostatus_q == bphs_pkg::StEqual |-> obucket_q == '0)
    else $error("equal-slot result with non-zero bucket");
  a_full_bucket_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && ostatus_q == bphs_pkg::StFull |-> obucket_q == '0)
    else $error("full-table result with non-zero bucket");
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bphs_pkg::S_IDLE |-> !we)
    else $error("table written while idle");
  a_hash_done_in_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdone |-> state_q == bphs_pkg::S_HASH)
    else $error("hash finished outside hash state");

endmodule
`default_nettype wire

@@ sv/bphs_ram.sv @@
`default_nettype none
module bphs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire [$clog2(DEPTH)-1:0] waddr_i,
  input  wire [WIDTH-1:0]         wdata_i,
  input  wire [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

@@ sv/bphs_hash.sv @@
`default_nettype none
module bphs_hash (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start_i,
  input  wire [31:0]         entry_i,
  output logic               done_o,
  output bphs_pkg::idx_t     bucket_o
);

  logic [63:0] x_q, res_q, key, k0, coef, prod, res_new, x_mix, fin;
  logic [31:0] ma, mb;
  logic [2:0]  step_q;
  logic [1:0]  sub;
  logic        busy_q, done_q;
  bphs_pkg::idx_t bucket_q;

  // 64-bit low product from three 32x32 partial products
  always_comb begin
    key  = {16'b0, entry_i[31:16], 16'b0, entry_i[15:0]};
    k0   = key ^ (key >> 30);
    coef = (step_q < 3'd3) ? bphs_pkg::Mix1 : bphs_pkg::Mix2;
    sub  = (step_q < 3'd3) ? step_q[1:0] : 2'(step_q - 3'd3);
    unique case (sub)
      2'd0: begin ma = x_q[31:0];  mb = coef[31:0];  end
      2'd1: begin ma = x_q[31:0];  mb = coef[63:32]; end
      default: begin ma = x_q[63:32]; mb = coef[31:0]; end
    endcase
    prod    = {32'b0, ma} * {32'b0, mb};
    res_new = (sub == 2'd0) ? prod : (res_q + {prod[31:0], 32'b0});
    x_mix   = res_new ^ (res_new >> 27);
    fin     = res_new ^ (res_new >> 31);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= 3'd0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= 3'd0;
    end else if (busy_q) begin
      step_q <= step_q + 3'd1;
      if (step_q == 3'd5) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= k0;
    end else if (busy_q) begin
      res_q <= res_new;
      if (step_q == 3'd2) begin
        x_q <= x_mix;
      end
      if (step_q == 3'd5) begin
        bucket_q <= fin[bphs_pkg::IdxW-1:0];
      end
    end
  end

  assign done_o   = done_q;
  assign bucket_o = bucket_q;

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
`default_nettype none
module tb_top;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] slot_a;
    logic [15:0] slot_b;
  } pair_req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [9:0] bucket;
  } pair_rsp_t;

  localparam int ProbeEmpty = 0;
  localparam int ProbeMatch = 1;
  localparam int ProbeFull  = 2;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;

  body_pair_hash_set i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  logic [31:0] bucket_store [bphs_pkg::TableDepth];
  pair_req_t   pending_reqs [$];
  pair_rsp_t   expected_rsps [$];
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          errors = 0;

  function automatic logic [9:0] home_of(logic [31:0] entry);
    logic [63:0] k;
    k = {16'd0, entry[31:16], 16'd0, entry[15:0]};
    k = k ^ (k >> 30);
    k = k * bphs_pkg::Mix1;
    k = k ^ (k >> 27);
    k = k * bphs_pkg::Mix2;
    k = k ^ (k >> 31);
    return k[9:0];
  endfunction

  function automatic int probe(logic [31:0] entry, output logic [9:0] at);
    logic [9:0] idx;
    idx = home_of(entry);
    for (int n = 0; n < bphs_pkg::TableDepth; n++) begin
      if (bucket_store[idx] == 0) begin
        at = idx;
        return ProbeEmpty;
      end
      if (bucket_store[idx] == entry) begin
        at = idx;
        return ProbeMatch;
      end
      idx = idx + 10'd1;
    end
    at = '0;
    return ProbeFull;
  endfunction

  function automatic pair_rsp_t predict_pair(pair_req_t rq);
    pair_rsp_t  r;
    logic [15:0] lo, hi;
    logic [31:0] entry, moved;
    logic [9:0] at, idx, at2;
    int         pr;
    r = '0;
    if (rq.slot_a == rq.slot_b) begin
      r.status = bphs_pkg::StEqual;
      return r;
    end
    lo = (rq.slot_a < rq.slot_b) ? rq.slot_a : rq.slot_b;
    hi = (rq.slot_a < rq.slot_b) ? rq.slot_b : rq.slot_a;
    entry = {lo, hi};
    pr = probe(entry, at);
    r.bucket = at;
    if (pr == ProbeFull) begin
      r.status = bphs_pkg::StFull;
      r.bucket = '0;
    end else if (rq.mode == bphs_pkg::ModeInsert) begin
      if (pr == ProbeMatch) r.status = bphs_pkg::StPresent;
      else begin
        bucket_store[at] = entry;
        r.status = bphs_pkg::StInserted;
      end
    end else if (rq.mode == bphs_pkg::ModeRemove) begin
      if (pr == ProbeMatch) begin
        bucket_store[at] = 0;
        idx = at + 10'd1;
        for (int n = 0; n < bphs_pkg::TableDepth; n++) begin
          moved = bucket_store[idx];
          if (moved == 0) break;
          bucket_store[idx] = 0;
          if (probe(moved, at2) == ProbeEmpty) bucket_store[at2] = moved;
          idx = idx + 10'd1;
        end
        r.status = bphs_pkg::StRemoved;
      end else r.status = bphs_pkg::StMissing;
    end else r.status = (pr == ProbeMatch) ? bphs_pkg::StFound : bphs_pkg::StAbsent;
    return r;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      expected_rsps.push_back(predict_pair(pending_reqs.pop_front()));
    end
    if ((!s_axis_tvalid_i || s_axis_tready_o) && rst_ni) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i <= {6'd0, pending_reqs[0].slot_b, pending_reqs[0].slot_a,
                           pending_reqs[0].mode};
      end else s_axis_tvalid_i <= 1'b0;
    end
    m_axis_tready_i <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor
  always @(posedge clk_i) begin
    pair_rsp_t got, exp_rsp;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      got.status = m_axis_tdata_o[2:0];
      got.bucket = m_axis_tdata_o[12:3];
      if (expected_rsps.size() == 0) begin
        $display("%0t unexpected item: status %0d bucket %0d", $time,
                 got.status, got.bucket);
        errors++;
      end else begin
        exp_rsp = expected_rsps.pop_front();
        if (got.status !== exp_rsp.status) begin
          $display("%0t status: expected %0d actual %0d", $time, exp_rsp.status,
                   got.status);
          errors++;
        end
        if (got.bucket !== exp_rsp.bucket) begin
          $display("%0t bucket: expected %0d actual %0d", $time, exp_rsp.bucket,
                   got.bucket);
          errors++;
        end
      end
    end
  end

  task automatic add_req(logic [1:0] m, logic [15:0] a, logic [15:0] b);
    pair_req_t rq;
    rq.mode = m;
    rq.slot_a = a;
    rq.slot_b = b;
    pending_reqs.push_back(rq);
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || s_axis_tvalid_i || expected_rsps.size() != 0)
      @(posedge clk_i);
  endtask

  initial begin
    logic [15:0] pa [64];
    logic [15:0] pb [64];
    int k;
    for (int i = 0; i < bphs_pkg::TableDepth; i++) bucket_store[i] = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    add_req(bphs_pkg::ModeFind, 16'd0, 16'd0);
    add_req(bphs_pkg::ModeInsert, 16'hffff, 16'hffff);
    add_req(bphs_pkg::ModeInsert, 16'd0, 16'hffff);
    add_req(bphs_pkg::ModeInsert, 16'hffff, 16'd0);
    add_req(bphs_pkg::ModeFind, 16'hffff, 16'd0);
    add_req(2'd3, 16'd0, 16'hffff);
    add_req(bphs_pkg::ModeInsert, 16'd1, 16'd2);
    add_req(bphs_pkg::ModeFind, 16'd2, 16'd1);
    add_req(bphs_pkg::ModeRemove, 16'd2, 16'd1);
    add_req(bphs_pkg::ModeRemove, 16'd2, 16'd1);
    add_req(bphs_pkg::ModeFind, 16'd1, 16'd2);
    add_req(bphs_pkg::ModeInsert, 16'h5555, 16'haaaa);
    add_req(bphs_pkg::ModeRemove, 16'haaaa, 16'h5555);
    add_req(bphs_pkg::ModeRemove, 16'hffff, 16'd0);
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 37 : 46) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 37 : 46) : 0;
      for (int i = 0; i < 64; i++) begin
        pa[i] = 16'($urandom);
        pb[i] = (i < 32) ? 16'($urandom_range(15)) : 16'($urandom);
      end
      for (int i = 0; i < 262; i++) begin
        k = $urandom_range(63);
        case ($urandom_range(9))
          0: add_req(2'($urandom_range(3)), 16'($urandom), 16'($urandom));
          1: add_req(2'($urandom_range(3)), pa[k], pa[k]);
          2, 3, 4: add_req(bphs_pkg::ModeInsert, pa[k], pb[k]);
          5, 6: add_req(bphs_pkg::ModeRemove, pb[k], pa[k]);
          default: add_req($urandom_range(1) ? bphs_pkg::ModeFind : 2'd3, pb[k], pa[k]);
        endcase
      end
      drain();
    end
    repeat (200) @(posedge clk_i);
    if (errors == 0 && expected_rsps.size() == 0) $display("body_pair_hash_set test passed");
    else $display("body_pair_hash_set test failed");
    $finish;
  end

  initial begin
    #200000000;
    $display("body_pair_hash_set test failed");
    $finish;
  end
endmodule
`default_nettype wire

@@ filelist.f @@
sv/bphs_pkg.sv
sv/bphs_ram.sv
sv/bphs_hash.sv
sv/body_pair_hash_set.sv
tb/sv/tb_top.sv
